>>> src/pgpt_pkg.sv
// ----------------------------------------------------------------------------
// pgpt_pkg
// Shared types and constants of the polygon gate point test block.
// ----------------------------------------------------------------------------
package pgpt_pkg;

   localparam int COORD_BITS        = 32;
   localparam int MAX_VERTICES_DEF  = 16;
   localparam int MIN_POLY_VERTICES = 3;
   localparam int CNT_BITS          = 5;
   localparam int IDX_BITS          = 4;

   // request mode codes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // control from the sequencer to the edge unit; vld and seed are aligned with memory read data
   typedef struct packed {
      logic start;   // clear the parity flag for a new query
      logic vld;     // read data holds a vertex
      logic seed;    // vertex is the closing one, no edge yet
   } edge_ctl_type;

   typedef struct packed {
      logic busy;    // an edge is still in the pipeline
      logic parity;  // even-odd crossing parity
   } edge_stat_type;

endpackage

>>> src/polygon_gate_point_test.sv
// ----------------------------------------------------------------------------
// polygon_gate_point_test
// Even-odd ray-casting test of a point against a polygon held in vertex memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | mode, vertex_index, point_x, point_y
//  rsp     | out       | rsp_valid / rsp_ready  | inside_res
//  csr     | in        | csr_wr_en              | csr_wr_data (vertex_count)
//
//  A load request writes both vertex memories if its index is below the depth.
//  A query reads the closing vertex and then each of the n vertices, one memory
//  read per vertex, passes each edge through the registered memory read and the
//  edge pipeline stages, and then loads the result.
//  With fewer than three vertices a query skips the vertex walk and goes to the result.
//  Reset clears the vertex count and control state; memory contents are kept.
//  A held result does not block loads; a query waits at its end for rsp_ready.
// ----------------------------------------------------------------------------
module polygon_gate_point_test
   import pgpt_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [IDX_BITS-1:0]   req_vertex_index,
   input  logic [COORD_BITS-1:0] req_point_x,
   input  logic [COORD_BITS-1:0] req_point_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_inside_res,
   input  logic                  csr_wr_en,
   input  logic [CNT_BITS-1:0]   csr_wr_data
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int NW = (CW > CNT_BITS) ? CW : CNT_BITS;
   localparam int IW = (AW > IDX_BITS) ? AW : IDX_BITS;

   logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

   state_type state_ff, state_in;

   logic [CNT_BITS-1:0]          count_ff;
   logic [CW-1:0]                n_ff, n_in;
   logic [CW-1:0]                rd_idx_ff, rd_idx_in;
   logic                         short_ff, short_in;
   logic signed [COORD_BITS-1:0] q_x_ff, q_y_ff;
   logic signed [COORD_BITS-1:0] rd_x_ff, rd_y_ff;
   logic                         rd_v_ff, rd_v_in;
   logic                         rd_seed_ff, rd_seed_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_inside_ff, rsp_inside_in;

   logic                         req_fire, load_fire, query_fire;
   logic                         wr_en;
   logic [IW-1:0]                idx_ext;
   logic [AW-1:0]                wr_addr, rd_addr;
   logic [CW-1:0]                n_last, rd_prev;
   logic [NW-1:0]                cnt_ext, n_sat;
   logic                         start;

   edge_ctl_type  ctl;
   edge_stat_type stat;

   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_mode == MODE_LOAD);
   assign query_fire = req_fire && (req_mode == MODE_QUERY);

   assign idx_ext = IW'(req_vertex_index);
   assign wr_addr = idx_ext[AW-1:0];
   assign wr_en   = load_fire && (32'(req_vertex_index) < 32'(MAX_VERTICES));

   // saturate the programmed count to the memory depth
   always_comb begin
      cnt_ext  = NW'(count_ff);
      n_sat    = (cnt_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : cnt_ext;
      n_in     = n_sat[CW-1:0];
      short_in = n_sat < NW'(MIN_POLY_VERTICES);
   end

   // closing vertex first, then 0 .. n-1
   assign n_last  = n_ff - CW'(1);
   assign rd_prev = rd_idx_ff - CW'(1);
   assign rd_addr = (rd_idx_ff == '0) ? n_last[AW-1:0] : rd_prev[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      rd_v_in       = 1'b0;
      rd_seed_in    = 1'b0;
      start         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_inside_in = rsp_inside_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (query_fire) begin
               start     = 1'b1;
               rd_idx_in = '0;
               state_in  = short_in ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            rd_v_in    = 1'b1;
            rd_seed_in = (rd_idx_ff == '0);
            rd_idx_in  = rd_idx_ff + CW'(1);
            if (rd_idx_ff == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !stat.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = short_ff || stat.parity;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      rd_seed_ff    <= rd_seed_in;
      rsp_inside_ff <= rsp_inside_in;
      if (query_fire) begin
         n_ff     <= n_in;
         short_ff <= short_in;
         q_x_ff   <= req_point_x;
         q_y_ff   <= req_point_y;
      end
   end

   // vertex memories, one write and one registered read port each
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= req_point_x;
         mem_y[wr_addr] <= req_point_y;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   assign ctl.start = start;
   assign ctl.vld   = rd_v_ff;
   assign ctl.seed  = rd_seed_ff;

   pgpt_edge_unit u_edge (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .vx    (rd_x_ff),
      .vy    (rd_y_ff),
      .qx    (q_x_ff),
      .qy    (q_y_ff),
      .stat  (stat)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule

>>> src/pgpt_edge_unit.sv
// ----------------------------------------------------------------------------
// pgpt_edge_unit
// Three-stage edge pipeline: differences, cross products, compare and toggle.
// ----------------------------------------------------------------------------
module pgpt_edge_unit
   import pgpt_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  edge_ctl_type                 ctl,
   input  logic signed [COORD_BITS-1:0] vx,
   input  logic signed [COORD_BITS-1:0] vy,
   input  logic signed [COORD_BITS-1:0] qx,
   input  logic signed [COORD_BITS-1:0] qy,
   output edge_stat_type                stat
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic signed [COORD_BITS-1:0] prv_x_ff, prv_y_ff;

   logic                 d_v_ff, d_v_in;
   logic signed [DW-1:0] d_dy_ff, d_dy_in;
   logic signed [DW-1:0] d_dxq_ff, d_dxq_in;
   logic signed [DW-1:0] d_dxe_ff, d_dxe_in;
   logic signed [DW-1:0] d_dyq_ff, d_dyq_in;

   logic                 m_v_ff, m_v_in;
   logic                 m_pos_ff, m_pos_in;
   logic signed [PW-1:0] m_lhs_ff, m_lhs_in;
   logic signed [PW-1:0] m_rhs_ff, m_rhs_in;

   logic flag_ff, flag_in;
   logic straddle, crossing;

   // edge (j, i): i is the vertex just read, j the one before it
   always_comb begin
      straddle = (vy > qy) != (prv_y_ff > qy);
      d_v_in   = ctl.vld && !ctl.seed && straddle;
      d_dy_in  = $signed({prv_y_ff[COORD_BITS-1], prv_y_ff}) - $signed({vy[COORD_BITS-1], vy});
      d_dxq_in = $signed({qx[COORD_BITS-1], qx}) - $signed({vx[COORD_BITS-1], vx});
      d_dxe_in = $signed({prv_x_ff[COORD_BITS-1], prv_x_ff})
                 - $signed({vx[COORD_BITS-1], vx});
      d_dyq_in = $signed({qy[COORD_BITS-1], qy}) - $signed({vy[COORD_BITS-1], vy});
   end

   always_comb begin
      m_v_in   = d_v_ff;
      m_pos_in = !d_dy_ff[DW-1] && (d_dy_ff != '0);
      m_lhs_in = d_dxq_ff * d_dy_ff;
      m_rhs_in = d_dxe_ff * d_dyq_ff;
   end

   // point left of the crossing, with the inequality flipped for edges that rise from j to i
   always_comb begin
      crossing = m_pos_ff ? (m_lhs_ff < m_rhs_ff) : (m_rhs_ff < m_lhs_ff);
      flag_in  = flag_ff;
      if (ctl.start) begin
         flag_in = 1'b0;
      end else if (m_v_ff && crossing) begin
         flag_in = !flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
      end else begin
         d_v_ff <= d_v_in;
         m_v_ff <= m_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.vld) begin
         prv_x_ff <= vx;
         prv_y_ff <= vy;
      end
      d_dy_ff  <= d_dy_in;
      d_dxq_ff <= d_dxq_in;
      d_dxe_ff <= d_dxe_in;
      d_dyq_ff <= d_dyq_in;
      m_pos_ff <= m_pos_in;
      m_lhs_ff <= m_lhs_in;
      m_rhs_ff <= m_rhs_in;
      flag_ff  <= flag_in;
   end

   assign stat.busy   = d_v_ff || m_v_ff;
   assign stat.parity = flag_ff;

endmodule

>>> src/pgpt_checker.sv
// ----------------------------------------------------------------------------
// pgpt_checker
// Port-level checks of request and response sequencing.
// ----------------------------------------------------------------------------
module pgpt_checker
   import pgpt_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_mode,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_inside_res
);

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inside_res))
      else $error("response changed while stalled");

   // a load never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("response after load request");

   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_LOAD |=> req_ready)
      else $error("ready dropped after load request");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_QUERY |=> !req_ready)
      else $error("ready held during query");

   // results are only launched while a query is in progress
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without a query in progress");

endmodule

bind polygon_gate_point_test pgpt_checker u_pgpt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_mode       (req_mode),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_inside_res (rsp_inside_res)
);
